// ----- sv/tiq_pkg.sv -----
// Shared types and constants for the tamper input qualifier.
package tiq_pkg;

  localparam int unsigned HISTORY_BITS_DEF = 8;
  localparam int unsigned TIMER_W          = 16;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned CFG_DATA_W       = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX          = 16'hFFFF;
  localparam logic [TIMER_W-1:0] MODULE_SETTLE_RST  = 16'd10;
  localparam logic [TIMER_W-1:0] MAGNET_HOLD_RST    = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULE_SETTLE = 1'b0,
    CFG_MAGNET_HOLD   = 1'b1
  } cfg_idx_e;

  // Qualified level of the magnet and module channels.
  // OFF: magnet absent / module inserted. ON: magnet present / module removed.
  typedef enum logic [1:0] {
    TRI_UNKNOWN = 2'd0,
    TRI_OFF     = 2'd1,
    TRI_ON      = 2'd2
  } tri_level_e;

  typedef struct packed {
    logic cover_open;
    logic terminal_open;
    logic magnet_present;
    logic module_removed;
    logic cover_open_event;
    logic cover_close_event;
    logic terminal_open_event;
    logic terminal_close_event;
    logic magnet_start_event;
    logic magnet_end_event;
    logic module_removed_event;
    logic module_inserted_event;
  } result_t;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    sat_inc = (v == TIMER_MAX) ? TIMER_MAX : v + 1'b1;
  endfunction

endpackage

// ----- sv/tamper_input_qualifier.sv -----
// Tamper input qualifier: debounce and qualification of four meter tamper pins.
//
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_stall_o   cover/terminal/magnet/module pins, hold
//  out       source     out_valid_o / out_stall_i levels and event pulses, one word per accepted input
//  cfg       sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One word per cycle while the output is not stalled; combinational state update
// and result logic feed the output register, or the skid stage when stalled.
// A one-word skid stage keeps input open while a result is stalled; input
// stalls only when that skid stage is full. Reset clears all histories, levels,
// timers and valid flags and loads the register defaults.
module tamper_input_qualifier
  import tiq_pkg::*;
#(
  parameter int unsigned HISTORY_BITS = HISTORY_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cover_pin_i,
  input  logic                  terminal_pin_i,
  input  logic                  magnet_pin_i,
  input  logic                  module_pin_i,
  input  logic                  module_hold_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  cover_open_o,
  output logic                  terminal_open_o,
  output logic                  magnet_present_o,
  output logic                  module_removed_o,
  output logic                  cover_open_event_o,
  output logic                  cover_close_event_o,
  output logic                  terminal_open_event_o,
  output logic                  terminal_close_event_o,
  output logic                  magnet_start_event_o,
  output logic                  magnet_end_event_o,
  output logic                  module_removed_event_o,
  output logic                  module_inserted_event_o
);

  // configuration
  logic [TIMER_W-1:0] settle_q, hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= MODULE_SETTLE_RST;
      hold_q   <= MAGNET_HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODULE_SETTLE: settle_q <= cfg_data_i[TIMER_W-1:0];
        CFG_MAGNET_HOLD:   hold_q   <= cfg_data_i[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  logic [HISTORY_BITS-1:0] cov_hist_q, cov_hist_d, trm_hist_q, trm_hist_d;
  logic [HISTORY_BITS-1:0] mag_hist_q, mag_hist_d, mod_hist_q, mod_hist_d;
  logic                    cov_lvl_q, cov_lvl_d, trm_lvl_q, trm_lvl_d;
  tri_level_e              mag_lvl_q, mag_lvl_d, mod_lvl_q, mod_lvl_d;
  logic [TIMER_W-1:0]      mag_tmr_q, mag_tmr_d, rem_tmr_q, rem_tmr_d;
  logic [TIMER_W-1:0]      ins_tmr_q, ins_tmr_d;
  result_t                 res_d;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    logic [TIMER_W-1:0] rem_t, ins_t, rem_inc, ins_inc;
    cov_hist_d = {cov_hist_q[HISTORY_BITS-2:0], cover_pin_i};
    trm_hist_d = {trm_hist_q[HISTORY_BITS-2:0], terminal_pin_i};
    mag_hist_d = {mag_hist_q[HISTORY_BITS-2:0], magnet_pin_i};
    mod_hist_d = {mod_hist_q[HISTORY_BITS-2:0], module_pin_i};
    cov_lvl_d  = cov_lvl_q;
    trm_lvl_d  = trm_lvl_q;
    mag_lvl_d  = mag_lvl_q;
    mod_lvl_d  = mod_lvl_q;
    mag_tmr_d  = mag_tmr_q;
    res_d      = '0;

    // module channel
    rem_t   = module_hold_i ? '0 : rem_tmr_q;
    ins_t   = module_hold_i ? '0 : ins_tmr_q;
    rem_inc = sat_inc(rem_t);
    ins_inc = sat_inc(ins_t);
    rem_tmr_d = rem_t;
    ins_tmr_d = ins_t;
    if (&mod_hist_d) begin
      ins_tmr_d = '0;
      rem_tmr_d = rem_inc;
      if (rem_inc >= settle_q) begin
        rem_tmr_d = settle_q;
        res_d.module_removed_event = (mod_lvl_q == TRI_OFF);
        mod_lvl_d = TRI_ON;
      end
    end else if (~|mod_hist_d) begin
      rem_tmr_d = '0;
      ins_tmr_d = ins_inc;
      if (ins_inc >= settle_q) begin
        ins_tmr_d = settle_q;
        res_d.module_inserted_event = (mod_lvl_q == TRI_ON);
        mod_lvl_d = TRI_OFF;
      end
    end

    // cover and terminal: settled low is open
    if (~|cov_hist_d) begin
      res_d.cover_open_event = !cov_lvl_q;
      cov_lvl_d = 1'b1;
    end else if (&cov_hist_d) begin
      res_d.cover_close_event = cov_lvl_q;
      cov_lvl_d = 1'b0;
    end
    if (~|trm_hist_d) begin
      res_d.terminal_open_event = !trm_lvl_q;
      trm_lvl_d = 1'b1;
    end else if (&trm_hist_d) begin
      res_d.terminal_close_event = trm_lvl_q;
      trm_lvl_d = 1'b0;
    end

    // magnet: settled low is field present
    if (~|mag_hist_d) begin
      mag_tmr_d = sat_inc(mag_tmr_q);
      if (mag_lvl_q != TRI_ON && mag_tmr_d > hold_q) begin
        res_d.magnet_start_event = (mag_lvl_q == TRI_OFF);
        mag_lvl_d = TRI_ON;
      end
    end else if (&mag_hist_d) begin
      mag_tmr_d = '0;
      res_d.magnet_end_event = (mag_lvl_q == TRI_ON);
      mag_lvl_d = TRI_OFF;
    end

    res_d.cover_open     = cov_lvl_d;
    res_d.terminal_open  = trm_lvl_d;
    res_d.magnet_present = (mag_lvl_d == TRI_ON);
    res_d.module_removed = (mod_lvl_d == TRI_ON);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cov_hist_q <= '0;
      trm_hist_q <= '0;
      mag_hist_q <= '0;
      mod_hist_q <= '0;
      cov_lvl_q  <= 1'b0;
      trm_lvl_q  <= 1'b0;
      mag_lvl_q  <= TRI_UNKNOWN;
      mod_lvl_q  <= TRI_UNKNOWN;
      mag_tmr_q  <= '0;
      rem_tmr_q  <= '0;
      ins_tmr_q  <= '0;
    end else if (in_acc) begin
      cov_hist_q <= cov_hist_d;
      trm_hist_q <= trm_hist_d;
      mag_hist_q <= mag_hist_d;
      mod_hist_q <= mod_hist_d;
      cov_lvl_q  <= cov_lvl_d;
      trm_lvl_q  <= trm_lvl_d;
      mag_lvl_q  <= mag_lvl_d;
      mod_lvl_q  <= mod_lvl_d;
      mag_tmr_q  <= mag_tmr_d;
      rem_tmr_q  <= rem_tmr_d;
      ins_tmr_q  <= ins_tmr_d;
    end
  end

  // output register with skid stage
  logic    out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_free;

  assign in_stall_o = skid_vld_q;
  assign out_free   = !out_vld_q || !out_stall_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (out_free) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = in_acc;
        out_d     = res_d;
      end
    end else if (in_acc) begin
      skid_vld_d = 1'b1;
      skid_d     = res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o             = out_vld_q;
  assign cover_open_o            = out_q.cover_open;
  assign terminal_open_o         = out_q.terminal_open;
  assign magnet_present_o        = out_q.magnet_present;
  assign module_removed_o        = out_q.module_removed;
  assign cover_open_event_o      = out_q.cover_open_event;
  assign cover_close_event_o     = out_q.cover_close_event;
  assign terminal_open_event_o   = out_q.terminal_open_event;
  assign terminal_close_event_o  = out_q.terminal_close_event;
  assign magnet_start_event_o    = out_q.magnet_start_event;
  assign magnet_end_event_o      = out_q.magnet_end_event;
  assign module_removed_event_o  = out_q.module_removed_event;
  assign module_inserted_event_o = out_q.module_inserted_event;

`ifndef SYNTH
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid stage holds a word while output register is empty");

  a_cover_event_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((!cover_open_event_o || cover_open_o) &&
                   (!cover_close_event_o || !cover_open_o)))
    else $error("cover event disagrees with cover level");

  a_magnet_event_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((!magnet_start_event_o || magnet_present_o) &&
                   (!magnet_end_event_o || !magnet_present_o)))
    else $error("magnet event disagrees with magnet level");

  a_module_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(module_removed_event_o && module_inserted_event_o))
    else $error("module removed and inserted events in one word");
`endif

endmodule
